// File: design/wsf_pkg.sv
// Package: shared types, constants and lookup tables for the weighted softmax block.
package wsf_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NE0    = 2'd0,
        CFG_NE1    = 2'd1,
        CFG_MINOCC = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_LOAD,
        S_E_RD,
        S_E_NEG,
        S_X_M1,
        S_X_M2,
        S_X_M3,
        S_E_MW,
        S_E_ACC,
        S_N_RD,
        S_N_MUL,
        S_N_DIV,
        S_N_WAIT,
        S_N_WR,
        S_L_INIT,
        S_L_NORM,
        S_L_MUL,
        S_L_ACC,
        S_L_SCALE,
        S_L_SAT,
        S_FX,
        S_F_RD,
        S_F_MW,
        S_F_ACC,
        S_OUT_RD,
        S_OUT
    } t_state;

    // 2^(-k/8) in Q1.24
    function automatic logic [24:0] pow2_at(input logic [3:0] k);
        logic [24:0] v;
        case (k)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd15384775;
            4'd2:    v = 25'd14107901;
            4'd3:    v = 25'd12937002;
            4'd4:    v = 25'd11863283;
            4'd5:    v = 25'd10878679;
            4'd6:    v = 25'd9975792;
            4'd7:    v = 25'd9147843;
            default: v = 25'd8388608;
        endcase
        return v;
    endfunction

    // log2(1 + k/8) in Q16.16
    function automatic logic [16:0] log2_at(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd0;
            4'd1:    v = 17'd11136;
            4'd2:    v = 17'd21098;
            4'd3:    v = 17'd30109;
            4'd4:    v = 17'd38336;
            4'd5:    v = 17'd45904;
            4'd6:    v = 17'd52911;
            4'd7:    v = 17'd59434;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/wsf_mul.sv
// Shared signed multiplier with a registered product.
module wsf_mul (
    input  logic                i_clk,
    input  logic signed [33:0]  i_a,
    input  logic signed [26:0]  i_b,
    output logic signed [60:0]  o_p
);
    logic signed [60:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: design/wsf_div.sv
// Restoring divider: 32-bit saturating quotient, one bit per cycle.
module wsf_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [58:0]  i_dividend,
    input  logic [39:0]  i_divisor,
    output logic         o_done,
    output logic [31:0]  o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [39:0] r_rem, n_rem;
    logic [39:0] r_dsr, n_dsr;
    logic [31:0] r_low, n_low;
    logic [31:0] r_q, n_q;
    logic [40:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_low  = r_low;
        n_q    = r_q;
        trial  = {r_rem, r_low[31]};
        if (i_start) begin
            n_dsr = i_divisor;
            n_low = i_dividend[31:0];
            n_rem = {13'd0, i_dividend[58:32]};
            n_cnt = 6'd0;
            n_q   = '0;
            // quotient would not fit in 32 bits
            if ({13'd0, i_dividend[58:32]} >= i_divisor) begin
                n_q    = '1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_low = {r_low[30:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = 40'(trial - {1'b0, r_dsr});
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = trial[39:0];
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_low <= n_low;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: design/weighted_softmax_with_floor_top.sv
// Top level: run storage, sequencer and output register of the weighted softmax block.
//
// Input channel (i_valid / o_stall): one transaction per entry of a run, with its spin,
// Q16.16 logit and Q2.16 k-point weight; i_last_in closes the run. Up to 64 entries
// are kept, later ones only count for i_last_in. During loading o_stall stays low.
// After the last entry o_stall stays high while a small sequencer drives one shared
// multiplier and one bit-serial divider over the stored run: an exponent pass, a
// normalize pass paced by the 32-step divider, and, when some occupation falls under
// the floor, three log2 evaluations (skipped when the electron count or the sum is
// zero), a recompute pass and a second normalize pass. Results then leave one at a
// time through the output register, in load order.
// Output channel (o_valid / i_stall): one transaction per stored entry; o_last_out
// marks the final one. A result waits in the output register while i_stall is high,
// and the next run may load while the last result of a run still waits.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) take effect at once;
// write only between runs. Synchronous active-low reset clears the run and restores
// the register defaults; the stores need no clearing.
module weighted_softmax_with_floor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_spin,
    input  logic [31:0]  i_logit,
    input  logic [17:0]  i_k_weight,
    input  logic         i_last_in,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_occupation,
    output logic [31:0]  o_adjusted_logit,
    output logic         o_entry_clamped,
    output logic         o_run_clamped,
    output logic         o_last_out,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import wsf_pkg::*;

    t_state r_state, n_state;

    logic [25:0]        r_ne0, r_ne1, r_ne;
    logic [23:0]        r_minocc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic signed [31:0] r_max, n_max;
    logic [39:0]        r_sum, n_sum;
    logic               r_clamp, n_clamp;
    logic               r_floor, n_floor;
    logic               r_second, n_second;
    logic [32:0]        r_neg, n_neg;
    logic [4:0]         r_ip, n_ip;
    logic               r_zero, n_zero;
    logic [2:0]         r_j, n_j;
    logic [24:0]        r_e, n_e;
    logic [24:0]        r_ec, n_ec;
    logic signed [31:0] r_minx, n_minx;
    logic [39:0]        r_lx, n_lx;
    logic [5:0]         r_lp, n_lp;
    logic [1:0]         r_lk, n_lk;
    logic signed [27:0] r_acc, n_acc;

    logic               r_ovalid, n_ovalid;
    logic [31:0]        r_o_occ, n_o_occ;
    logic [31:0]        r_o_adj, n_o_adj;
    logic               r_o_cl, n_o_cl;
    logic               r_o_run, n_o_run;
    logic               r_o_last, n_o_last;

    // stores
    logic [49:0] mem_a [0:MAX_ENTRIES-1];
    logic [25:0] mem_e [0:MAX_ENTRIES-1];
    logic [31:0] mem_occ [0:MAX_ENTRIES-1];
    logic [49:0] r_rd_a;
    logic [25:0] r_rd_e;
    logic [31:0] r_rd_occ;

    logic               a_we, e_we, occ_we;
    logic [25:0]        e_wd;
    logic [31:0]        occ_wd;

    logic signed [33:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [60:0] mul_p;
    logic               div_start, div_done;
    logic [31:0]        div_q;

    logic               in_acc, out_acc, is_last, lx_done;
    logic signed [31:0] rd_logit;
    logic [17:0]        rd_w;
    logic [24:0]        rd_e;
    logic               rd_cl;
    logic [31:0]        q_val;
    logic               cl_new;
    logic [24:0]        x_v;
    logic [24:0]        fe;
    logic [40:0]        s41;
    logic [27:0]        lterm;
    logic [3:0]         lj;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_ovalid && !i_stall;
    assign is_last  = (r_idx + 1'b1) == r_n;
    assign lx_done  = r_lx[39] || (r_lp == 6'd0);
    assign rd_logit = r_rd_a[49:18];
    assign rd_w     = r_rd_a[17:0];
    assign rd_e     = r_rd_e[24:0];
    assign rd_cl    = r_rd_e[25];
    assign q_val    = (r_sum == '0) ? 32'd0 : div_q;
    assign cl_new   = q_val < {8'd0, r_minocc};
    assign x_v      = 25'(pow2_at({1'b0, r_j}) - 25'(mul_p[45:13]));
    assign fe       = rd_cl ? r_ec : rd_e;
    assign s41      = {1'b0, r_sum} + {14'd0, mul_p[42:16]};
    assign lj       = {1'b0, r_lx[38:36]};
    assign lterm    = 28'({r_lp, 16'd0}) + 28'(log2_at(lj)) + 28'(mul_p[29:13]);

    wsf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    wsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({mul_p[50:0], 8'd0}),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:    if (in_acc && i_last_in) n_state = S_E_RD;
            S_E_RD:    n_state = S_E_NEG;
            S_E_NEG:   n_state = S_X_M1;
            S_X_M1:    n_state = S_X_M2;
            S_X_M2:    n_state = S_X_M3;
            S_X_M3:    n_state = r_floor ? S_F_RD : S_E_MW;
            S_E_MW:    n_state = S_E_ACC;
            S_E_ACC:   n_state = is_last ? S_N_RD : S_E_RD;
            S_N_RD:    n_state = S_N_MUL;
            S_N_MUL:   n_state = S_N_DIV;
            S_N_DIV:   n_state = S_N_WAIT;
            S_N_WAIT:  if (div_done) n_state = S_N_WR;
            S_N_WR: begin
                if (!is_last) begin
                    n_state = S_N_RD;
                end else if (!r_second && (r_clamp || cl_new)) begin
                    n_state = S_L_INIT;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            S_L_INIT:  n_state = (r_ne == '0 || r_sum == '0) ? S_FX : S_L_NORM;
            S_L_NORM:  if (lx_done) n_state = S_L_MUL;
            S_L_MUL:   n_state = S_L_ACC;
            S_L_ACC:   n_state = (r_lk == 2'd2) ? S_L_SCALE : S_L_NORM;
            S_L_SCALE: n_state = S_L_SAT;
            S_L_SAT:   n_state = S_FX;
            S_FX:      n_state = S_X_M1;
            S_F_RD:    n_state = S_F_MW;
            S_F_MW:    n_state = S_F_ACC;
            S_F_ACC:   n_state = is_last ? S_N_RD : S_F_RD;
            S_OUT_RD:  n_state = S_OUT;
            S_OUT: begin
                if (!r_ovalid || !i_stall) n_state = is_last ? S_LOAD : S_OUT_RD;
            end
            default:   n_state = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_idx    = r_idx;
        n_max    = r_max;
        n_sum    = r_sum;
        n_clamp  = r_clamp;
        n_floor  = r_floor;
        n_second = r_second;
        n_neg    = r_neg;
        n_ip     = r_ip;
        n_zero   = r_zero;
        n_j      = r_j;
        n_e      = r_e;
        n_ec     = r_ec;
        n_minx   = r_minx;
        n_lx     = r_lx;
        n_lp     = r_lp;
        n_lk     = r_lk;
        n_acc    = r_acc;
        n_ovalid = out_acc ? 1'b0 : r_ovalid;
        n_o_occ  = r_o_occ;
        n_o_adj  = r_o_adj;
        n_o_cl   = r_o_cl;
        n_o_run  = r_o_run;
        n_o_last = r_o_last;
        a_we      = 1'b0;
        e_we      = 1'b0;
        occ_we    = 1'b0;
        e_wd      = '0;
        occ_wd    = q_val;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < CNT_W'(MAX_ENTRIES)) begin
                        a_we  = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        if ($signed(i_logit) > r_max) n_max = $signed(i_logit);
                    end
                    if (i_last_in) begin
                        n_n      = (r_cnt < CNT_W'(MAX_ENTRIES)) ? r_cnt + 1'b1 : r_cnt;
                        n_idx    = '0;
                        n_sum    = '0;
                        n_clamp  = 1'b0;
                        n_floor  = 1'b0;
                        n_second = 1'b0;
                    end
                end
            end
            S_E_RD: begin
            end
            S_E_NEG: begin
                n_neg = 33'({r_max[31], r_max} - {rd_logit[31], rd_logit});
            end
            S_X_M1: begin
                mul_a = {1'b0, r_neg};
                mul_b = {10'd0, LOG2E_Q16};
            end
            S_X_M2: begin
                n_zero = mul_p[60:32] >= 29'd25;
                n_ip   = mul_p[36:32];
                n_j    = mul_p[31:29];
                mul_a  = {9'd0, 25'(pow2_at({1'b0, mul_p[31:29]})
                                - pow2_at({1'b0, mul_p[31:29]} + 4'd1))};
                mul_b  = {14'd0, mul_p[28:16]};
            end
            S_X_M3: begin
                n_e = r_zero ? 25'd0 : (x_v >> r_ip);
                if (r_floor) begin
                    n_ec  = r_zero ? 25'd0 : (x_v >> r_ip);
                    n_idx = '0;
                    n_sum = '0;
                end else begin
                    e_we = 1'b1;
                    e_wd = {1'b0, (r_zero ? 25'd0 : (x_v >> r_ip))};
                end
            end
            S_E_MW: begin
                mul_a = {9'd0, r_e};
                mul_b = {9'd0, rd_w};
            end
            S_E_ACC: begin
                n_sum = s41[40] ? '1 : s41[39:0];
                n_idx = is_last ? '0 : r_idx + 1'b1;
            end
            S_N_RD: begin
            end
            S_N_MUL: begin
                mul_a = {9'd0, rd_e};
                mul_b = {1'b0, r_ne};
            end
            S_N_DIV: begin
                div_start = 1'b1;
            end
            S_N_WAIT: begin
            end
            S_N_WR: begin
                occ_we = 1'b1;
                if (!r_second) begin
                    e_we    = 1'b1;
                    e_wd    = {cl_new, rd_e};
                    n_clamp = r_clamp || cl_new;
                end
                n_idx = is_last ? '0 : r_idx + 1'b1;
            end
            S_L_INIT: begin
                if (r_ne == '0) begin
                    n_minx = 32'sh7FFFFFFF;
                end else if (r_sum == '0) begin
                    n_minx = 32'sh80000000;
                end
                n_lx  = r_sum;
                n_lp  = 6'd39;
                n_lk  = 2'd0;
                n_acc = -28'sd2097152;
            end
            S_L_NORM: begin
                // shift up until the leading one sits in the top bit or the position reaches zero
                if (!lx_done) begin
                    n_lx = {r_lx[38:0], 1'b0};
                    n_lp = r_lp - 6'd1;
                end
            end
            S_L_MUL: begin
                mul_a = {17'd0, 17'(log2_at(lj + 4'd1) - log2_at(lj))};
                mul_b = {14'd0, r_lx[35:23]};
            end
            S_L_ACC: begin
                n_acc = (r_lk == 2'd2) ? r_acc - $signed(lterm) : r_acc + $signed(lterm);
                n_lk  = r_lk + 2'd1;
                n_lp  = 6'd39;
                n_lx  = (r_lk == 2'd0) ? {16'd0, r_minocc} : {14'd0, r_ne};
            end
            S_L_SCALE: begin
                mul_a = 34'(r_acc);
                mul_b = {11'd0, LN2_Q16};
            end
            S_L_SAT: begin
                // floor of the Q16.16 product, clipped to 32 bits
                if (mul_p[60:47] == '0 || mul_p[60:47] == '1) begin
                    n_minx = mul_p[47:16];
                end else begin
                    n_minx = mul_p[60] ? 32'sh80000000 : 32'sh7FFFFFFF;
                end
            end
            S_FX: begin
                n_floor = 1'b1;
                n_neg   = r_minx[31] ? 33'(-{r_minx[31], r_minx}) : 33'd0;
            end
            S_F_RD: begin
            end
            S_F_MW: begin
                e_we  = 1'b1;
                e_wd  = {rd_cl, fe};
                mul_a = {9'd0, fe};
                mul_b = {9'd0, rd_w};
            end
            S_F_ACC: begin
                n_sum    = s41[40] ? '1 : s41[39:0];
                n_idx    = is_last ? '0 : r_idx + 1'b1;
                n_second = is_last ? 1'b1 : r_second;
            end
            S_OUT_RD: begin
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_o_occ  = r_rd_occ;
                    n_o_adj  = rd_cl ? sat32({{2{r_minx[31]}}, r_minx}
                                             + {{2{r_max[31]}}, r_max})
                                     : rd_logit;
                    n_o_cl   = rd_cl;
                    n_o_run  = r_clamp;
                    n_o_last = is_last;
                    n_idx    = r_idx + 1'b1;
                    if (is_last) begin
                        n_cnt = '0;
                        n_max = 32'sh80000000;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_max    <= 32'sh80000000;
            r_ovalid <= 1'b0;
            r_clamp  <= 1'b0;
            r_ne0    <= 26'd65536;
            r_ne1    <= 26'd65536;
            r_minocc <= 24'd17;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_max    <= n_max;
            r_ovalid <= n_ovalid;
            r_clamp  <= n_clamp;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_NE0:    r_ne0    <= i_cfg_data[25:0];
                    CFG_NE1:    r_ne1    <= i_cfg_data[25:0];
                    CFG_MINOCC: r_minocc <= i_cfg_data[23:0];
                    CFG_NONE:   ;
                    default:    ;
                endcase
            end
        end
        if (r_state == S_LOAD && in_acc && i_last_in) r_ne <= i_spin ? r_ne1 : r_ne0;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_floor  <= n_floor;
        r_second <= n_second;
        r_neg    <= n_neg;
        r_ip     <= n_ip;
        r_zero   <= n_zero;
        r_j      <= n_j;
        r_e      <= n_e;
        r_ec     <= n_ec;
        r_minx   <= n_minx;
        r_lx     <= n_lx;
        r_lp     <= n_lp;
        r_lk     <= n_lk;
        r_acc    <= n_acc;
        r_o_occ  <= n_o_occ;
        r_o_adj  <= n_o_adj;
        r_o_cl   <= n_o_cl;
        r_o_run  <= n_o_run;
        r_o_last <= n_o_last;
    end

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (a_we) mem_a[r_cnt[IDX_W-1:0]] <= {i_logit, i_k_weight};
        if (e_we) mem_e[r_idx[IDX_W-1:0]] <= e_wd;
        if (occ_we) mem_occ[r_idx[IDX_W-1:0]] <= occ_wd;
        r_rd_a   <= mem_a[r_idx[IDX_W-1:0]];
        r_rd_e   <= mem_e[r_idx[IDX_W-1:0]];
        r_rd_occ <= mem_occ[r_idx[IDX_W-1:0]];
    end

    assign o_stall          = (r_state != S_LOAD);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_ovalid;
    assign o_occupation     = r_o_occ;
    assign o_adjusted_logit = r_o_adj;
    assign o_entry_clamped  = r_o_cl;
    assign o_run_clamped    = r_o_run;
    assign o_last_out       = r_o_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond store depth");

    a_clamp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_entry_clamped && !o_run_clamped))
        else $error("entry clamped without run clamp");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_idx < r_n))
        else $error("sequencer index past run length");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_N_DIV) |=> (r_state == S_N_WAIT))
        else $error("divider start not followed by wait");

    a_last_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && is_last && (!r_ovalid || !i_stall)) |=> (r_state == S_LOAD))
        else $error("run end did not return to load");
endmodule

// File: tb/testbench.sv
// Testbench for weighted_softmax_with_floor_top: directed and random runs checked against a predictor.
module testbench;
    import wsf_pkg::*;

    typedef struct {
        logic [31:0] occupation;
        logic [31:0] adjusted_logit;
        bit          entry_clamped;
        bit          run_clamped;
        bit          last_out;
    } softmax_result_t;

    // Fixed-point softmax predictor and the queue of expected results.
    class softmax_scoreboard;
        longint unsigned pow2_t[9] = '{16777216, 15384775, 14107901, 12937002, 11863283,
                                       10878679, 9975792, 9147843, 8388608};
        longint          log2_t[9] = '{0, 11136, 21098, 30109, 38336, 45904, 52911,
                                       59434, 65536};
        logic [25:0]     electrons[2];
        logic [23:0]     occ_floor;
        longint          logits[MAX_ENTRIES];
        longint unsigned weights[MAX_ENTRIES];
        int              count;
        longint          run_max;
        softmax_result_t expected_q[$];
        int              failures;

        function new();
            electrons[0] = 26'd65536;
            electrons[1] = 26'd65536;
            occ_floor    = 24'd17;
            count        = 0;
            run_max      = -64'sd2147483648;
            failures     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_NE0:    electrons[0] = data[25:0];
                CFG_NE1:    electrons[1] = data[25:0];
                CFG_MINOCC: occ_floor = data[23:0];
                default: ;
            endcase
        endfunction

        function longint unsigned exp_fix(longint d);
            longint unsigned u, ip, f, j, r, v;
            if (d >= 0) return 64'd16777216;
            u  = (longint'(-d) * 64'd94548) >> 16;
            ip = u >> 16;
            if (ip >= 25) return 0;
            f = u & 64'hFFFF;
            j = f >> 13;
            r = f & 64'h1FFF;
            v = pow2_t[j] - (((pow2_t[j] - pow2_t[j + 1]) * r) >> 13);
            return v >> ip;
        endfunction

        function longint log2_fix(longint unsigned x);
            int              p;
            longint unsigned y, mf, j, r;
            p = 63;
            while (p > 0 && x[p] == 1'b0) p--;
            y  = (p >= 16) ? (x >> (p - 16)) : (x << (16 - p));
            mf = y & 64'hFFFF;
            j  = mf >> 13;
            r  = mf & 64'h1FFF;
            return longint'(p) * 65536 + log2_t[j] +
                   longint'(((log2_t[j + 1] - log2_t[j]) * r) >> 13);
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned weighted_total(longint unsigned e[MAX_ENTRIES], int n);
            longint unsigned s;
            s = 0;
            for (int i = 0; i < n; i++) begin
                s += (e[i] * weights[i]) >> 16;
                if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
            end
            return s;
        endfunction

        function longint unsigned share(longint unsigned e, longint unsigned s,
                                        longint unsigned ne);
            longint unsigned q;
            q = (s != 0) ? ((e * ne) << 8) / s : 0;
            return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
        endfunction

        // Note an accepted entry; a closing entry produces the run's results.
        function void note_entry(bit spin, logic [31:0] logit, logic [17:0] wt, bit last);
            longint unsigned e[MAX_ENTRIES];
            longint unsigned occ[MAX_ENTRIES];
            longint          dx[MAX_ENTRIES];
            bit              cl[MAX_ENTRIES];
            longint unsigned s, ne;
            longint          lg, minx, l2;
            bit              any;
            softmax_result_t res;
            lg = longint'($signed(logit));
            if (count < MAX_ENTRIES) begin
                logits[count]  = lg;
                weights[count] = 64'(wt);
                if (lg > run_max) run_max = lg;
                count++;
            end
            if (!last) return;
            ne = 64'(electrons[spin]);
            for (int i = 0; i < count; i++) begin
                dx[i] = logits[i] - run_max;
                e[i]  = exp_fix(dx[i]);
            end
            s   = weighted_total(e, count);
            any = 0;
            for (int i = 0; i < count; i++) begin
                occ[i] = share(e[i], s, ne);
                cl[i]  = occ[i] < occ_floor;
                any |= cl[i];
            end
            if (any) begin
                if (ne == 0) begin
                    minx = 64'sd2147483647;
                end else if (s == 0) begin
                    minx = -64'sd2147483648;
                end else begin
                    l2   = log2_fix(s) + log2_fix(64'(occ_floor)) - log2_fix(ne) - 32 * 65536;
                    minx = clip32((l2 * 45426) >>> 16);
                end
                for (int i = 0; i < count; i++) begin
                    if (cl[i]) begin
                        dx[i] = minx;
                        e[i]  = exp_fix(minx > 0 ? 0 : minx);
                    end
                end
                s = weighted_total(e, count);
                for (int i = 0; i < count; i++) occ[i] = share(e[i], s, ne);
            end
            for (int i = 0; i < count; i++) begin
                res.occupation     = occ[i][31:0];
                res.adjusted_logit = 32'(clip32(dx[i] + run_max));
                res.entry_clamped  = cl[i];
                res.run_clamped    = any;
                res.last_out       = (i + 1 == count);
                expected_q.push_back(res);
            end
            count   = 0;
            run_max = -64'sd2147483648;
        endfunction

        function void check_result(softmax_result_t got);
            softmax_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result, occupation %0h", got.occupation);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.occupation !== exp_r.occupation) begin
                $error("occupation: expected %0h actual %0h", exp_r.occupation, got.occupation);
                failures++;
            end
            if (got.adjusted_logit !== exp_r.adjusted_logit) begin
                $error("adjusted_logit: expected %0h actual %0h",
                       exp_r.adjusted_logit, got.adjusted_logit);
                failures++;
            end
            if (got.entry_clamped !== exp_r.entry_clamped) begin
                $error("entry_clamped: expected %0b actual %0b",
                       exp_r.entry_clamped, got.entry_clamped);
                failures++;
            end
            if (got.run_clamped !== exp_r.run_clamped) begin
                $error("run_clamped: expected %0b actual %0b", exp_r.run_clamped, got.run_clamped);
                failures++;
            end
            if (got.last_out !== exp_r.last_out) begin
                $error("last_out: expected %0b actual %0b", exp_r.last_out, got.last_out);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_spin = 1'b0;
    logic [31:0] i_logit = '0;
    logic [17:0] i_k_weight = '0;
    logic        i_last_in = 1'b0;
    logic        i_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_NONE;
    logic [31:0] i_cfg_data = '0;
    logic        o_stall, o_valid, o_entry_clamped, o_run_clamped, o_last_out, o_cfg_ready;
    logic [31:0] o_occupation, o_adjusted_logit;

    softmax_scoreboard occ_board = new();
    int     send_pct = 0;
    int     recv_pct = 0;
    int     hold_req = 0;
    int     hold_left = 0;
    longint cycles = 0;

    weighted_softmax_with_floor_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("** weighted_softmax_with_floor_top: FAILED **");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    always @(posedge i_clk) begin
        softmax_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.occupation     = o_occupation;
            got.adjusted_logit = o_adjusted_logit;
            got.entry_clamped  = o_entry_clamped;
            got.run_clamped    = o_run_clamped;
            got.last_out       = o_last_out;
            occ_board.check_result(got);
        end
    end

    task automatic send_entry(bit spin, logic [31:0] logit, logic [17:0] wt, bit last);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_spin     <= spin;
        i_logit    <= logit;
        i_k_weight <= wt;
        i_last_in  <= last;
        do @(posedge i_clk); while (o_stall);
        occ_board.note_entry(spin, logit, wt, last);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (occ_board.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        occ_board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One run of n entries; logits either spread over the full range or clustered.
    task automatic send_run(int n);
        bit          spin, clustered, unit_wt;
        logic [31:0] base, lg;
        logic [17:0] wt;
        spin      = $urandom_range(1);
        clustered = ($urandom_range(3) != 0);
        unit_wt   = ($urandom_range(2) == 0);
        base      = $urandom;
        for (int i = 0; i < n; i++) begin
            lg = clustered ? base + ($urandom & 32'h001F_FFFF) - 32'h0010_0000 : $urandom;
            wt = unit_wt ? 18'd65536 : 18'($urandom);
            send_entry(spin, lg, wt, i == n - 1);
        end
    endtask

    initial begin
        int n;
        int len;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero sum, zero electrons, zero floor, all clamped.
        send_entry(1'b0, 32'h7FFF_FFFF, 18'h3FFFF, 1'b0);
        send_entry(1'b0, 32'h8000_0000, 18'h00000, 1'b0);
        send_entry(1'b0, 32'h0000_0000, 18'd65536, 1'b1);
        send_entry(1'b1, 32'h1234_5678, 18'h00000, 1'b1);
        wait_drained();
        write_reg(CFG_NE0, 32'h0);
        write_reg(CFG_NE1, 32'h03FF_FFFF);
        send_entry(1'b1, 32'h0001_0000, 18'd65536, 1'b0);
        send_entry(1'b0, 32'hFFF0_0000, 18'd65536, 1'b1);
        send_entry(1'b1, 32'h7FFF_0000, 18'h3FFFF, 1'b0);
        send_entry(1'b1, 32'h8000_0000, 18'd1, 1'b1);
        wait_drained();
        write_reg(CFG_MINOCC, 32'h0);
        write_reg(CFG_NE0, 32'd65536);
        send_entry(1'b0, 32'h7FFF_FFFF, 18'd65536, 1'b0);
        send_entry(1'b0, 32'h8000_0000, 18'd65536, 1'b1);
        wait_drained();
        write_reg(CFG_MINOCC, 32'h00FF_FFFF);
        send_entry(1'b0, 32'h0000_0000, 18'd65536, 1'b0);
        send_entry(1'b0, 32'h0000_0000, 18'd65536, 1'b0);
        send_entry(1'b0, 32'h0000_0000, 18'd65536, 1'b1);
        wait_drained();

        // Random: three idle profiles, fresh registers before each.
        for (int phase = 0; phase < 3; phase++) begin
            send_pct = (phase == 0) ? 8 : (phase == 1) ? 56 : 0;
            recv_pct = (phase == 0) ? 56 : (phase == 1) ? 8 : 0;
            wait_drained();
            write_reg(CFG_NE0, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 16) << 16);
            write_reg(CFG_NE1, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 16) << 16);
            write_reg(CFG_MINOCC, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4096));
            if (phase == 1) hold_req = 3000;
            // one run near or past the store depth, then short and medium runs
            len = $urandom_range(60, 70);
            send_run(len);
            n = len;
            while (n < 68) begin
                len = ($urandom_range(9) < 2) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                send_run(len);
                n += len;
            end
        end

        wait_drained();
        if (occ_board.failures == 0) begin
            $display("** weighted_softmax_with_floor_top: PASSED **");
        end else begin
            $display("** weighted_softmax_with_floor_top: FAILED **");
        end
        $finish;
    end
endmodule

// File: sim.f
design/wsf_pkg.sv
design/wsf_mul.sv
design/wsf_div.sv
design/weighted_softmax_with_floor_top.sv
tb/testbench.sv
